// ----- hw/rtl/sed_pkg.sv -----
// Shared types and constants for the string literal escape decoder.
// No dependencies; imported by the channel interfaces, the top level and the checker.
`timescale 1ns / 1ps

package sed_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned CountW = 13;
  localparam logic [CountW-1:0] MaxLen = CountW'(4096);

  // Character codes
  localparam logic [CharW-1:0] ChBackslash = 8'h5C;
  localparam logic [CharW-1:0] ChQuote     = 8'h22;
  localparam logic [CharW-1:0] ChApos      = 8'h27;
  localparam logic [CharW-1:0] ChQuestion  = 8'h3F;
  localparam logic [CharW-1:0] ChLowX      = 8'h78;
  localparam logic [CharW-1:0] ChLowN      = 8'h6E;
  localparam logic [CharW-1:0] ChLowT      = 8'h74;
  localparam logic [CharW-1:0] ChLowV      = 8'h76;
  localparam logic [CharW-1:0] ChLowB      = 8'h62;
  localparam logic [CharW-1:0] ChLowR      = 8'h72;
  localparam logic [CharW-1:0] ChLowF      = 8'h66;
  localparam logic [CharW-1:0] ChLowA      = 8'h61;
  localparam logic [CharW-1:0] ChZero      = 8'h30;
  localparam logic [CharW-1:0] ChSeven     = 8'h37;
  localparam logic [CharW-1:0] ChNine      = 8'h39;
  localparam logic [CharW-1:0] ChUpA       = 8'h41;
  localparam logic [CharW-1:0] ChUpF       = 8'h46;
  localparam logic [CharW-1:0] ChLowAHex   = 8'h61;
  localparam logic [CharW-1:0] ChLowFHex   = 8'h66;

  // Control bytes for simple escapes
  localparam logic [CharW-1:0] CtlNl  = 8'h0A;
  localparam logic [CharW-1:0] CtlTab = 8'h09;
  localparam logic [CharW-1:0] CtlVt  = 8'h0B;
  localparam logic [CharW-1:0] CtlBs  = 8'h08;
  localparam logic [CharW-1:0] CtlCr  = 8'h0D;
  localparam logic [CharW-1:0] CtlFf  = 8'h0C;
  localparam logic [CharW-1:0] CtlBel = 8'h07;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeEsc    = 2'd1,
    ModeHex    = 2'd2,
    ModeOct    = 2'd3
  } mode_e;

  typedef struct packed {
    logic [CharW-1:0]  out_byte;
    logic              is_last;
    logic              warn_unknown;
    logic [CountW-1:0] decoded_count;
  } res_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] cnt);
    logic [CountW-1:0] r;
    r = (cnt < MaxLen) ? cnt + CountW'(1) : cnt;
    return r;
  endfunction

endpackage

// ----- hw/rtl/sed_chan_if.sv -----
// Valid/ready channel interfaces for the escape decoder: input bytes and decoded results.
// Depends on sed_pkg.
`timescale 1ns / 1ps

interface sed_in_if;
  import sed_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface sed_out_if;
  import sed_pkg::*;
  logic              valid;
  logic              ready;
  logic [CharW-1:0]  out_byte;
  logic              is_last;
  logic              warn_unknown;
  logic [CountW-1:0] decoded_count;

  modport source (output valid, output out_byte, output is_last, output warn_unknown,
                  output decoded_count, input ready);
  modport sink   (input valid, input out_byte, input is_last, input warn_unknown,
                  input decoded_count, output ready);
endinterface

// ----- hw/rtl/string_literal_escape_decoder.sv -----
// Top level of the C string literal escape decoder.
// Depends on sed_pkg and the channel interfaces in sed_chan_if.sv.
//
// Usage:
//   in_i carries the body bytes of a string literal, one byte per transaction,
//   starting after the opening quote. out_o carries the decoded bytes; the
//   closing quote yields a zero byte with is_last set and the literal's count.
//   Each result carries the running decoded count, saturating at 4096.
//   Results are registered in the buffer on acceptance and offered in order.
//   Throughput: one input byte per cycle while the receiver keeps up. A byte
//   that ends a hex or octal escape can yield two results; the second one
//   occupies the result buffer and drops in_i.ready for one cycle.
//   Results sit in a three-entry buffer; in_i.ready is high while at most one
//   result is held, so a stalled receiver back-pressures the input after that.
//   Reset empties the buffer, clears the count and returns to normal mode.
`timescale 1ns / 1ps

module string_literal_escape_decoder (
  input  logic     clk_i,
  input  logic     rst_ni,
  sed_in_if.sink   in_i,
  sed_out_if.source out_o
);
  import sed_pkg::*;

  localparam int unsigned Depth = 3;

  mode_e             mode_q, mode_d;
  logic [CharW-1:0]  acc_q, acc_d;
  logic [CountW-1:0] cnt_q, cnt_d;

  res_t        buf_q [Depth];
  logic [1:0]  wptr_q, rptr_q, fill_q;
  logic [1:0]  wptr_d, rptr_d, fill_d;

  res_t        res0, res1;
  logic [1:0]  n_res;
  logic        accept, pop;

  logic [CharW-1:0]  c;
  logic              hex_ok, oct_ok;
  logic [3:0]        hex_dig;
  logic              esc_emit, do_normal;
  logic [CountW-1:0] cnt_mid;
  logic [CharW-1:0]  esc_val;
  logic              esc_warn;
  res_t              nres;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    logic [1:0] r;
    r = (p == 2'(Depth - 1)) ? 2'd0 : p + 2'd1;
    return r;
  endfunction

  assign c = in_i.char_in;

  always_comb begin
    hex_ok  = 1'b1;
    hex_dig = '0;
    if (c >= ChZero && c <= ChNine) begin
      hex_dig = c[3:0];
    end else if (c >= ChLowAHex && c <= ChLowFHex) begin
      hex_dig = c[3:0] + 4'd9;
    end else if (c >= ChUpA && c <= ChUpF) begin
      hex_dig = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
    oct_ok = (c >= ChZero && c <= ChSeven);
  end

  // Simple escape mapping
  always_comb begin
    esc_warn = 1'b0;
    case (c)
      ChLowN:      esc_val = CtlNl;
      ChLowT:      esc_val = CtlTab;
      ChLowV:      esc_val = CtlVt;
      ChLowB:      esc_val = CtlBs;
      ChLowR:      esc_val = CtlCr;
      ChLowF:      esc_val = CtlFf;
      ChLowA:      esc_val = CtlBel;
      ChBackslash,
      ChQuestion,
      ChApos,
      ChQuote:     esc_val = c;
      default: begin
        esc_val  = c;
        esc_warn = 1'b1;
      end
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    res0      = '0;
    res1      = '0;
    n_res     = 2'd0;
    esc_emit  = 1'b0;
    do_normal = 1'b0;
    nres      = '0;

    case (mode_q)
      ModeNormal: do_normal = 1'b1;
      ModeEsc: begin
        if (c == ChLowX) begin
          mode_d = ModeHex;
          acc_d  = '0;
        end else if (oct_ok) begin
          mode_d = ModeOct;
          acc_d  = {5'd0, c[2:0]};
        end else begin
          mode_d = ModeNormal;
          cnt_d  = sat_inc(cnt_q);
          res0   = '{out_byte: esc_val, is_last: 1'b0, warn_unknown: esc_warn,
                     decoded_count: cnt_d};
          n_res  = 2'd1;
        end
      end
      ModeHex: begin
        if (hex_ok) begin
          acc_d = {acc_q[3:0], hex_dig};
        end else begin
          esc_emit  = 1'b1;
          do_normal = 1'b1;
        end
      end
      ModeOct: begin
        if (oct_ok) begin
          acc_d = {acc_q[4:0], c[2:0]};
        end else begin
          esc_emit  = 1'b1;
          do_normal = 1'b1;
        end
      end
      default: mode_d = ModeNormal;
    endcase

    // A terminated hex/octal escape emits its value ahead of the current byte
    cnt_mid = cnt_q;
    if (esc_emit) begin
      mode_d  = ModeNormal;
      cnt_mid = sat_inc(cnt_q);
      cnt_d   = cnt_mid;
      res0    = '{out_byte: acc_q, is_last: 1'b0, warn_unknown: 1'b0,
                  decoded_count: cnt_mid};
      n_res   = 2'd1;
    end

    if (do_normal) begin
      if (c == ChQuote) begin
        nres   = '{out_byte: '0, is_last: 1'b1, warn_unknown: 1'b0,
                   decoded_count: cnt_mid};
        cnt_d  = '0;
        mode_d = ModeNormal;
      end else if (c == ChBackslash) begin
        mode_d = ModeEsc;
      end else begin
        cnt_d = sat_inc(cnt_mid);
        nres  = '{out_byte: c, is_last: 1'b0, warn_unknown: 1'b0,
                  decoded_count: cnt_d};
      end
      if (c != ChBackslash) begin
        if (esc_emit) begin
          res1 = nres;
        end else begin
          res0 = nres;
        end
        n_res = n_res + 2'd1;
      end
    end
  end

  assign in_i.ready = (fill_q <= 2'd1);
  assign accept     = in_i.valid && in_i.ready;
  assign out_o.valid = (fill_q != 2'd0);
  assign pop        = out_o.valid && out_o.ready;

  assign out_o.out_byte      = buf_q[rptr_q].out_byte;
  assign out_o.is_last       = buf_q[rptr_q].is_last;
  assign out_o.warn_unknown  = buf_q[rptr_q].warn_unknown;
  assign out_o.decoded_count = buf_q[rptr_q].decoded_count;

  always_comb begin
    logic [1:0] pushed;
    pushed = accept ? n_res : 2'd0;
    wptr_d = wptr_q;
    if (pushed == 2'd1) begin
      wptr_d = ptr_inc(wptr_q);
    end else if (pushed == 2'd2) begin
      wptr_d = ptr_inc(ptr_inc(wptr_q));
    end
    rptr_d = pop ? ptr_inc(rptr_q) : rptr_q;
    fill_d = fill_q + pushed - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      acc_q  <= '0;
      cnt_q  <= '0;
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (accept) begin
        mode_q <= mode_d;
        acc_q  <= acc_d;
        cnt_q  <= cnt_d;
      end
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // Result buffer payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept && n_res != 2'd0) begin
      buf_q[wptr_q] <= res0;
      if (n_res == 2'd2) begin
        buf_q[ptr_inc(wptr_q)] <= res1;
      end
    end
  end

endmodule

// ----- hw/rtl/sed_checker.sv -----
// Port-level checks for the escape decoder, bound to the top level.
// Depends on sed_pkg and string_literal_escape_decoder.
`timescale 1ns / 1ps

module sed_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [sed_pkg::CharW-1:0]  out_byte_i,
  input logic                      is_last_i,
  input logic                      warn_unknown_i,
  input logic [sed_pkg::CountW-1:0] decoded_count_i
);
  import sed_pkg::*;

  // Terminator is always a clean zero byte
  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_last_i |-> out_byte_i == '0 && !warn_unknown_i)
    else $error("terminator carries data or warning");

  // A warned byte is a counted data byte
  a_warn_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && warn_unknown_i |-> !is_last_i && decoded_count_i != '0)
    else $error("warning on terminator or uncounted byte");

  // Count never exceeds the saturation limit
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> decoded_count_i <= MaxLen)
    else $error("decoded count above limit");

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

endmodule

bind string_literal_escape_decoder sed_checker u_sed_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_byte_i      (out_o.out_byte),
  .is_last_i       (out_o.is_last),
  .warn_unknown_i  (out_o.warn_unknown),
  .decoded_count_i (out_o.decoded_count)
);

// ----- verif/string_literal_escape_decoder_tb.sv -----
// Testbench for string_literal_escape_decoder: directed and random string literal bodies.
// Depends on sed_pkg, the channel interfaces in sed_chan_if.sv and the decoder RTL.
`timescale 1ns / 1ps

module string_literal_escape_decoder_tb;
  import sed_pkg::*;

  logic clk;
  logic rst_ni;

  sed_in_if  in_ch ();
  sed_out_if out_ch ();

  string_literal_escape_decoder i_dut (
    .clk_i (clk),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Decoder state as the testbench tracks it
  mode_e             esc_mode;
  logic [CharW-1:0]  esc_acc;
  logic [CountW-1:0] lit_count;

  res_t        pending_results[$];
  int unsigned mismatch_count;
  bit          calm;

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver side: stalls about 30% of the cycles unless in a calm stretch
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      check_result();
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic check_result();
    res_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending, out_byte", out_ch.out_byte, 0);
      return;
    end
    want = pending_results.pop_front();
    if (out_ch.out_byte !== want.out_byte)
      report_mismatch("out_byte", out_ch.out_byte, want.out_byte);
    if (out_ch.is_last !== want.is_last)
      report_mismatch("is_last", out_ch.is_last, want.is_last);
    if (out_ch.warn_unknown !== want.warn_unknown)
      report_mismatch("warn_unknown", out_ch.warn_unknown, want.warn_unknown);
    if (out_ch.decoded_count !== want.decoded_count)
      report_mismatch("decoded_count", out_ch.decoded_count, want.decoded_count);
  endtask

  // ---------------------------------------------------------------- prediction

  function automatic void push_result(input logic [CharW-1:0] b, input logic last,
                                      input logic warn);
    res_t r;
    r.out_byte      = b;
    r.is_last       = last;
    r.warn_unknown  = warn;
    r.decoded_count = lit_count;
    pending_results.push_back(r);
  endfunction

  function automatic void emit_decoded(input logic [CharW-1:0] b, input logic warn);
    if (lit_count < MaxLen) lit_count = lit_count + CountW'(1);
    push_result(b, 1'b0, warn);
  endfunction

  function automatic void take_plain(input logic [CharW-1:0] c);
    if (c == ChQuote) begin
      push_result('0, 1'b1, 1'b0);
      lit_count = '0;
      esc_mode  = ModeNormal;
    end else if (c == ChBackslash) begin
      esc_mode = ModeEsc;
    end else begin
      emit_decoded(c, 1'b0);
    end
  endfunction

  function automatic int hex_digit(input logic [CharW-1:0] c);
    if (c >= ChZero && c <= ChNine) return int'(c - ChZero);
    if (c >= ChLowAHex && c <= ChLowFHex) return int'(c - ChLowAHex) + 10;
    if (c >= ChUpA && c <= ChUpF) return int'(c - ChUpA) + 10;
    return -1;
  endfunction

  function automatic bit is_octal(input logic [CharW-1:0] c);
    return c >= ChZero && c <= ChSeven;
  endfunction

  function automatic void take_escape(input logic [CharW-1:0] c);
    logic [CharW-1:0] v;
    logic             warn;
    warn = 1'b0;
    if (c == ChLowX) begin
      esc_mode = ModeHex;
      esc_acc  = '0;
      return;
    end
    if (is_octal(c)) begin
      esc_mode = ModeOct;
      esc_acc  = c - ChZero;
      return;
    end
    esc_mode = ModeNormal;
    case (c)
      ChLowN: v = CtlNl;
      ChLowT: v = CtlTab;
      ChLowV: v = CtlVt;
      ChLowB: v = CtlBs;
      ChLowR: v = CtlCr;
      ChLowF: v = CtlFf;
      ChLowA: v = CtlBel;
      ChBackslash, ChQuestion, ChApos, ChQuote: v = c;
      default: begin
        v    = c;
        warn = 1'b1;
      end
    endcase
    emit_decoded(v, warn);
  endfunction

  // Updates the tracked state for one accepted byte and queues its results
  function automatic void decode_char(input logic [CharW-1:0] c);
    int d;
    case (esc_mode)
      ModeNormal: take_plain(c);
      ModeEsc:    take_escape(c);
      ModeHex: begin
        d = hex_digit(c);
        if (d >= 0) begin
          esc_acc = {esc_acc[3:0], 4'(d)};
        end else begin
          esc_mode = ModeNormal;
          emit_decoded(esc_acc, 1'b0);
          take_plain(c);
        end
      end
      default: begin
        if (is_octal(c)) begin
          esc_acc = {esc_acc[4:0], 3'(c - ChZero)};
        end else begin
          esc_mode = ModeNormal;
          emit_decoded(esc_acc, 1'b0);
          take_plain(c);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- driving

  // Leaves valid high after the transaction; hold_input lowers it, a next call only while it idles
  task automatic send_char(input logic [CharW-1:0] c);
    while (!calm && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.char_in <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_char(c);
  endtask

  task automatic hold_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    hold_input();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CharW-1:0] pick_plain();
    logic [CharW-1:0] c;
    do c = 8'($urandom_range(255));
    while (c == ChQuote || c == ChBackslash);
    return c;
  endfunction

  function automatic logic [CharW-1:0] pick_simple_escape();
    case ($urandom_range(10))
      0: return ChLowN;
      1: return ChLowT;
      2: return ChLowV;
      3: return ChLowB;
      4: return ChLowR;
      5: return ChLowF;
      6: return ChLowA;
      7: return ChBackslash;
      8: return ChQuestion;
      9: return ChApos;
      default: return ChQuote;
    endcase
  endfunction

  function automatic logic [CharW-1:0] pick_unknown_escape();
    logic [CharW-1:0] c;
    do c = 8'($urandom_range(255));
    while (c == ChLowX || is_octal(c) || c == ChLowN || c == ChLowT || c == ChLowV ||
           c == ChLowB || c == ChLowR || c == ChLowF || c == ChLowA ||
           c == ChBackslash || c == ChQuestion || c == ChApos || c == ChQuote);
    return c;
  endfunction

  function automatic logic [CharW-1:0] pick_hex_digit();
    int unsigned v;
    v = $urandom_range(15);
    if (v < 10) return ChZero + 8'(v);
    if ($urandom_range(1) == 0) return ChLowAHex + 8'(v - 10);
    return ChUpA + 8'(v - 10);
  endfunction

  // One literal body of random escapes and bytes; now and then left unclosed
  task automatic send_random_literal(inout int unsigned sent);
    int unsigned pieces;
    int unsigned kind;
    int unsigned digits;
    pieces = $urandom_range(12);
    repeat (pieces) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        send_char(pick_plain());
        sent += 1;
      end else begin
        send_char(ChBackslash);
        sent += 1;
        if (kind < 55) begin
          send_char(pick_simple_escape());
          sent += 1;
        end else if (kind < 65) begin
          send_char(pick_unknown_escape());
          sent += 1;
        end else if (kind < 82) begin
          send_char(ChLowX);
          digits = ($urandom_range(9) == 0) ? $urandom_range(6) : $urandom_range(3);
          repeat (digits) send_char(pick_hex_digit());
          sent += digits + 1;
        end else begin
          digits = $urandom_range(1, 4);
          repeat (digits) send_char(ChZero + 8'($urandom_range(7)));
          sent += digits;
        end
      end
    end
    if ($urandom_range(9) != 0) begin
      send_char(ChQuote);
      sent += 1;
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_plain_bytes();
    send_char(8'h00);
    send_char(8'hFF);
    send_char(ChQuote);
    send_char(ChQuote);
    drain();
  endtask

  // Simple escapes incl. the corrected \f and \a, an escaped quote and an unknown letter
  task automatic test_simple_and_unknown_escapes();
    send_char(ChBackslash);
    send_char(ChLowN);
    send_char(ChBackslash);
    send_char(ChLowF);
    send_char(ChBackslash);
    send_char(ChLowA);
    send_char(ChBackslash);
    send_char(ChQuote);
    send_char(ChBackslash);
    send_char(8'h71);
    send_char(ChQuote);
    drain();
  endtask

  task automatic test_hex_escapes();
    // no digits, ended by a plain byte
    send_char(ChBackslash);
    send_char(ChLowX);
    send_char(8'h47);
    // long run keeps the low byte and is ended by the closing quote
    send_char(ChBackslash);
    send_char(ChLowX);
    send_char(8'h31);
    send_char(8'h66);
    send_char(8'h46);
    send_char(8'h61);
    send_char(ChQuote);
    drain();
  endtask

  task automatic test_octal_escapes();
    send_char(ChBackslash);
    send_char(8'h33);
    send_char(ChSeven);
    send_char(ChSeven);
    // backslash ends the escape and starts another one
    send_char(ChBackslash);
    send_char(8'h31);
    send_char(ChBackslash);
    send_char(ChLowT);
    send_char(ChQuote);
    drain();
  endtask

  task automatic test_count_saturation();
    repeat (int'(MaxLen) + 4) send_char(pick_plain());
    send_char(ChQuote);
    drain();
  endtask

  task automatic test_random_literals(input int unsigned n_items);
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_char(8'($urandom_range(255)));
        sent += 1;
      end else begin
        send_random_literal(sent);
      end
    end
    drain();
  endtask

  initial begin
    int unsigned n;
    clk            = 1'b0;
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.char_in  = '0;
    calm           = 1'b0;
    mismatch_count = 0;
    esc_mode       = ModeNormal;
    esc_acc        = '0;
    lit_count      = '0;
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_plain_bytes();
    test_simple_and_unknown_escapes();
    test_hex_escapes();
    test_octal_escapes();
    test_count_saturation();
    test_random_literals(400);
    calm = 1'b1;
    test_random_literals(200);
    calm = 1'b0;
    test_random_literals(400);

    for (n = 0; n < 10000 && pending_results.size() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never produced, count", pending_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
